// ----- hw/rtl/rws_pkg.sv -----
// Package for the roulette wheel selector: table sizes, request and response
// payload types, codes and the controller to datapath interface structs.
// Depends on nothing.
`default_nettype none

package rws_pkg;

   localparam int TABLE_DEPTH = 512;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W       = 26;
   localparam int FIT_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int ADJ_W       = 17;
   localparam int DIV_STEPS   = ADJ_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int PROD_W      = FRAC_W + SUM_W;
   localparam int SEL_W       = 9;
   localparam int ENTRY_W     = 10;
   localparam logic [FIT_W-1:0] MAX_FITNESS_RESET = 16'd100;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_SELECT = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [FIT_W-1:0] raw_fitness;
      logic [FIT_W-1:0] target;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SEL_W-1:0]   selected_index;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       div_start;
      logic       div_step;
      logic       accumulate;
      logic       multiply;
      logic       search_read;
      logic       search_compare;
      logic       respond;
      logic       respond_index;
      status_type respond_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       table_full;
      logic       table_empty;
      logic       div_last;
      logic       search_open;
      logic       rsp_stall;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/roulette_wheel_selector_core.sv -----
// Top level of the roulette wheel selector: joins the controller and the
// datapath. Depends on rws_pkg, rws_controller and rws_datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  rws_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  rws_pkg::rsp_type
//   csr_      in         csr_write_enable       max_fitness (16 bit)
//
// One request is worked on at a time. A load runs the 17 steps of the
// bit-serial divider and then accumulates. A select does a multiply, then one
// table memory read and one compare per binary search step. Clear, a rejected
// load or select and an unused command go straight to the response.
// Reset is synchronous and empties the table; the table memory needs no
// clearing pass. A finished response waits in the output register, and the
// next request is taken meanwhile; it stalls only if its own response is ready
// first.
`default_nettype none

module roulette_wheel_selector_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  rws_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output rws_pkg::rsp_type         rsp_data,
   input  wire                      csr_write_enable,
   input  wire [rws_pkg::FIT_W-1:0] csr_write_data
);

   rws_pkg::ctl_cmd_type   cmd;
   rws_pkg::dp_status_type status;

   rws_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rws_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/rws_datapath.sv -----
// Datapath of the roulette wheel selector: request register, divider,
// cumulative table memory, threshold multiplier, binary search and response
// register. Depends on rws_pkg.
`default_nettype none

module rws_datapath (
   input  wire                             clock,
   input  wire                             reset,
   input  rws_pkg::req_type                req_data,
   output rws_pkg::rsp_type                rsp_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   input  wire                             csr_write_enable,
   input  wire [rws_pkg::FIT_W-1:0]        csr_write_data,
   input  rws_pkg::ctl_cmd_type            cmd,
   output rws_pkg::dp_status_type          status
);

   localparam int AW = rws_pkg::ADDR_W;
   localparam int CW = rws_pkg::COUNT_W;
   localparam int SW = rws_pkg::SUM_W;
   localparam int QW = rws_pkg::ADJ_W;

   logic [SW-1:0]                 mem [rws_pkg::TABLE_DEPTH];

   rws_pkg::req_type              req_ff;
   logic [rws_pkg::FIT_W-1:0]     max_fitness_ff;
   logic [CW-1:0]                 entries_ff, entries_in;
   logic [SW-1:0]                 total_ff, total_in;
   logic [QW-1:0]                 denom_ff, rem_ff, quot_ff, dvd_ff;
   logic [rws_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [rws_pkg::PROD_W-1:0]    product_ff;
   logic [AW-1:0]                 lo_ff, hi_ff, mid_ff;
   logic [SW-1:0]                 rd_data_ff;
   rws_pkg::rsp_type              rsp_ff;
   logic                          rsp_valid_ff;

   logic [rws_pkg::FIT_W-1:0]     clamped;
   logic [QW-1:0]                 denom;
   logic [QW:0]                   trial;
   logic                          trial_fits;
   logic [SW:0]                   sum;
   logic [AW:0]                   lo_hi_sum;
   logic [AW-1:0]                 mid;
   logic [SW-1:0]                 threshold;

   always_comb begin
      clamped = (req_ff.raw_fitness > max_fitness_ff) ? max_fitness_ff : req_ff.raw_fitness;
      denom = {1'b0, max_fitness_ff} - {1'b0, clamped} + QW'(1);
      trial = {rem_ff, dvd_ff[QW-1]};
      trial_fits = trial >= {1'b0, denom_ff};
      sum = {1'b0, total_ff} + (SW + 1)'(quot_ff);
      lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid = lo_hi_sum[AW:1];
      threshold = product_ff[rws_pkg::PROD_W-1:rws_pkg::FRAC_W];
   end

   always_comb begin
      entries_in = entries_ff;
      total_in = total_ff;
      if (cmd.clear) begin
         entries_in = '0;
         total_in = '0;
      end else if (cmd.accumulate) begin
         entries_in = entries_ff + CW'(1);
         total_in = sum[SW] ? {SW{1'b1}} : sum[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fitness_ff <= rws_pkg::MAX_FITNESS_RESET;
         entries_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_fitness_ff <= csr_write_data;
         end
         entries_ff <= entries_in;
         total_ff <= total_in;
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.div_start) begin
         denom_ff <= denom;
         rem_ff <= '0;
         quot_ff <= '0;
         dvd_ff <= QW'(1) << (QW - 1);
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_fits ? QW'(trial - {1'b0, denom_ff}) : trial[QW-1:0];
         quot_ff <= {quot_ff[QW-2:0], trial_fits};
         dvd_ff <= {dvd_ff[QW-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + rws_pkg::DIV_CNT_W'(1);
      end
      if (cmd.accumulate) begin
         mem[entries_ff[AW-1:0]] <= total_in;
      end
      if (cmd.multiply) begin
         product_ff <= req_ff.target * total_ff;
         lo_ff <= '0;
         hi_ff <= AW'(entries_ff - CW'(1));
      end
      if (cmd.search_read) begin
         rd_data_ff <= mem[mid];
         mid_ff <= mid;
      end
      if (cmd.search_compare) begin
         if (rd_data_ff >= threshold) begin
            hi_ff <= mid_ff;
         end else begin
            lo_ff <= mid_ff + AW'(1);
         end
      end
      if (cmd.respond) begin
         rsp_ff.status <= cmd.respond_status;
         rsp_ff.selected_index <= cmd.respond_index ? rws_pkg::SEL_W'(lo_ff) : '0;
         rsp_ff.entry_count <= rws_pkg::ENTRY_W'(entries_ff);
      end
   end

   always_comb begin
      status.command = req_ff.command;
      status.table_full = entries_ff == CW'(rws_pkg::TABLE_DEPTH);
      status.table_empty = entries_ff == '0;
      status.div_last = div_cnt_ff == rws_pkg::DIV_CNT_W'(rws_pkg::DIV_STEPS - 1);
      status.search_open = lo_ff < hi_ff;
      status.rsp_stall = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rws_controller.sv -----
// Controller state machine of the roulette wheel selector: sequences clear,
// load (division, accumulate) and select (multiply, binary search).
// Depends on rws_pkg.
`default_nettype none

module rws_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  rws_pkg::dp_status_type status,
   output rws_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_DISPATCH   = 8'b0000_0010,
      S_DIVIDE     = 8'b0000_0100,
      S_ACCUMULATE = 8'b0000_1000,
      S_MULTIPLY   = 8'b0001_0000,
      S_SEARCH_RD  = 8'b0010_0000,
      S_SEARCH_CMP = 8'b0100_0000,
      S_FINISH     = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   rws_pkg::status_type code_ff, code_in;
   logic                index_ff, index_in;

   always_comb begin
      state_in = state_ff;
      code_in = code_ff;
      index_in = index_ff;
      cmd = '0;
      cmd.respond_status = code_ff;
      cmd.respond_index = index_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            code_in = rws_pkg::ST_OK;
            index_in = 1'b0;
            state_in = S_FINISH;
            case (status.command)
               rws_pkg::CMD_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               rws_pkg::CMD_LOAD: begin
                  if (status.table_full) begin
                     code_in = rws_pkg::ST_FULL;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in = S_DIVIDE;
                  end
               end
               rws_pkg::CMD_SELECT: begin
                  if (status.table_empty) begin
                     code_in = rws_pkg::ST_EMPTY;
                  end else begin
                     index_in = 1'b1;
                     state_in = S_MULTIPLY;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_ACCUMULATE;
            end
         end
         S_ACCUMULATE: begin
            cmd.accumulate = 1'b1;
            state_in = S_FINISH;
         end
         S_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in = S_SEARCH_RD;
         end
         S_SEARCH_RD: begin
            if (status.search_open) begin
               cmd.search_read = 1'b1;
               state_in = S_SEARCH_CMP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SEARCH_CMP: begin
            cmd.search_compare = 1'b1;
            state_in = S_SEARCH_RD;
         end
         S_FINISH: begin
            if (!status.rsp_stall) begin
               cmd.respond = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff <= rws_pkg::ST_OK;
         index_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff <= code_in;
         index_ff <= index_in;
      end
   end

endmodule

`default_nettype wire
